>>> hdl/spicfm_pkg.sv
// Shared types and constants for the SPI command framing master.
package spicfm_pkg;

  // Command codes on in_action
  localparam logic [2:0] ACT_RESET   = 3'd0;
  localparam logic [2:0] ACT_REG_RD  = 3'd1;
  localparam logic [2:0] ACT_REG_WR  = 3'd2;
  localparam logic [2:0] ACT_BIT_SET = 3'd3;
  localparam logic [2:0] ACT_BIT_CLR = 3'd4;
  localparam logic [2:0] ACT_BUF_RD  = 3'd5;
  localparam logic [2:0] ACT_BUF_WR  = 3'd6;
  localparam logic [2:0] ACT_NONE    = 3'd7;

  // Opcode bytes
  localparam logic [7:0] OP_RESET   = 8'hFF;
  localparam logic [7:0] OP_REG_RD  = 8'h00;
  localparam logic [7:0] OP_REG_WR  = 8'h40;
  localparam logic [7:0] OP_BIT_SET = 8'h80;
  localparam logic [7:0] OP_BIT_CLR = 8'hA0;
  localparam logic [7:0] OP_BUF_RD  = 8'h3A;
  localparam logic [7:0] OP_BUF_WR  = 8'h7A;
  localparam logic [7:0] ADDR_MASK  = 8'h1F;

  // What the second byte of a job does
  typedef enum logic [1:0] {
    B2_NONE  = 2'd0,
    B2_WRITE = 2'd1,
    B2_READ  = 2'd2
  } b2_mode_t;

  // One classified command, as handed from front to back
  typedef struct packed {
    logic       do_sel;
    logic       do_b1;
    logic [7:0] b1;
    b2_mode_t   b2_mode;
    logic [7:0] b2;
    logic       do_rel;
  } job_t;

  // One pin phase as presented on the result ports
  typedef struct packed {
    logic       cs_n;
    logic       sck;
    logic       mosi;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last;
  } phase_t;

endpackage

>>> hdl/spicfm_front.sv
// Front end: accepts commands, tracks the buffer frame and builds jobs.
module spicfm_front
  import spicfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       q_full,
  input  logic [2:0] in_action,
  input  logic [4:0] in_address,
  input  logic [7:0] in_data,
  input  logic [7:0] in_slave_byte,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  output logic       job_wr,
  output job_t       job
);

  logic       frame_r;
  logic       frame_nxt;
  logic       accept;
  logic [7:0] addr_bits;

  assign accept    = push && !q_full;
  assign addr_bits = {3'b000, in_address} & ADDR_MASK;
  assign job_wr    = accept && (in_action != ACT_NONE);

  // Classify the command
  always_comb begin
    job       = '0;
    frame_nxt = frame_r;
    unique case (in_action)
      ACT_RESET, ACT_REG_RD, ACT_REG_WR, ACT_BIT_SET, ACT_BIT_CLR: begin
        job.do_rel = 1'b1;
        if (frame_r) begin
          // open buffer frame: command dropped, frame closed
          frame_nxt = 1'b0;
        end else begin
          job.do_sel = 1'b1;
          job.do_b1  = 1'b1;
          job.b2     = in_data;
          unique case (in_action)
            ACT_RESET: begin
              job.b1      = OP_RESET;
              job.b2_mode = B2_NONE;
            end
            ACT_REG_RD: begin
              job.b1      = OP_REG_RD | addr_bits;
              job.b2_mode = B2_READ;
              job.b2      = in_slave_byte;
            end
            ACT_REG_WR: begin
              job.b1      = OP_REG_WR | addr_bits;
              job.b2_mode = B2_WRITE;
            end
            ACT_BIT_SET: begin
              job.b1      = OP_BIT_SET | addr_bits;
              job.b2_mode = B2_WRITE;
            end
            default: begin
              job.b1      = OP_BIT_CLR | addr_bits;
              job.b2_mode = B2_WRITE;
            end
          endcase
        end
      end
      ACT_BUF_RD: begin
        job.do_sel  = in_frame_start || !frame_r;
        job.do_b1   = in_frame_start || !frame_r;
        job.b1      = OP_BUF_RD;
        job.b2_mode = B2_READ;
        job.b2      = in_slave_byte;
        job.do_rel  = in_frame_end;
        frame_nxt   = !in_frame_end;
      end
      ACT_BUF_WR: begin
        job.do_sel  = in_frame_start || !frame_r;
        job.do_b1   = in_frame_start || !frame_r;
        job.b1      = OP_BUF_WR;
        job.b2_mode = B2_WRITE;
        job.b2      = in_data;
        job.do_rel  = in_frame_end;
        frame_nxt   = !in_frame_end;
      end
      ACT_NONE: begin
        frame_nxt = frame_r;
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= 1'b0;
    end else if (accept) begin
      frame_r <= frame_nxt;
    end
  end

  // A register command that meets an open frame closes it
  a_drop_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_r && (in_action == ACT_RESET || in_action == ACT_REG_RD ||
     in_action == ACT_REG_WR || in_action == ACT_BIT_SET ||
     in_action == ACT_BIT_CLR)) |=> !frame_r)
    else $error("open frame not closed by register command");

endmodule

>>> hdl/spicfm_job_fifo.sv
// Short job queue between the front end and the phase engine.
module spicfm_job_fifo
  import spicfm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  job_t wr_job,
  input  logic rd,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          ent_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = ent_r[rptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wptr_r] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> !full)
    else $error("job written to full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("job queue count out of range");

endmodule

>>> hdl/spicfm_phase_engine.sv
// Back end: steps through a job one pin phase per cycle, while pop keeps up, into the output register.
module spicfm_phase_engine
  import spicfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job_in,
  output logic       job_rd,
  input  logic       pop,
  output logic       empty,
  output logic       out_cs_n,
  output logic       out_sck,
  output logic       out_mosi,
  output logic [7:0] out_read_data,
  output logic       out_read_valid,
  output logic       out_last
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_B1   = 5'b00100,
    ST_B2   = 5'b01000,
    ST_REL  = 5'b10000
  } state_t;

  function automatic state_t from_b2(input job_t j);
    return j.do_rel ? ST_REL : ST_IDLE;
  endfunction

  function automatic state_t from_b1(input job_t j);
    return (j.b2_mode != B2_NONE) ? ST_B2 : from_b2(j);
  endfunction

  function automatic state_t from_sel(input job_t j);
    return j.do_b1 ? ST_B1 : from_b1(j);
  endfunction

  state_t     state_r, state_nxt;
  job_t       job_r, job_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       sel_lvl_r, clk_lvl_r, mosi_lvl_r;
  logic       ov_r, ov_nxt;
  phase_t     ph_r, ph;
  logic       can_emit;
  logic       emit;
  logic       sec_done;
  logic [2:0] bit_idx;

  assign can_emit = !ov_r || pop;
  assign bit_idx  = ~cnt_r[3:1];   // MSB first
  assign empty    = !ov_r;

  // Sequencer and phase generation
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cnt_nxt   = cnt_r;
    job_rd    = 1'b0;
    emit      = 1'b0;
    sec_done  = 1'b0;
    ph        = '0;
    ph.cs_n   = sel_lvl_r;
    ph.sck    = clk_lvl_r;
    ph.mosi   = mosi_lvl_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_rd    = 1'b1;
          job_nxt   = job_in;
          cnt_nxt   = '0;
          state_nxt = job_in.do_sel ? ST_SEL : from_sel(job_in);
        end
      end
      ST_SEL: begin
        emit     = can_emit;
        sec_done = 1'b1;
        ph.cs_n  = 1'b0;
      end
      ST_B1: begin
        emit     = can_emit;
        sec_done = (cnt_r == 4'd15);
        ph.sck   = cnt_r[0];
        ph.mosi  = job_r.b1[bit_idx];
      end
      ST_B2: begin
        emit     = can_emit;
        sec_done = (cnt_r == 4'd15);
        ph.sck   = cnt_r[0];
        if (job_r.b2_mode == B2_WRITE) begin
          ph.mosi = job_r.b2[bit_idx];
        end
      end
      ST_REL: begin
        emit     = can_emit;
        sec_done = (cnt_r == 4'd2);
        ph.cs_n  = (cnt_r == 4'd0) ? sel_lvl_r : 1'b1;
        ph.sck   = (cnt_r == 4'd2);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Section advance
    if (emit) begin
      cnt_nxt = sec_done ? 4'd0 : cnt_r + 4'd1;
      if (sec_done) begin
        unique case (state_r)
          ST_SEL:  state_nxt = from_sel(job_r);
          ST_B1:   state_nxt = from_b1(job_r);
          ST_B2:   state_nxt = from_b2(job_r);
          default: state_nxt = ST_IDLE;
        endcase
      end
      ph.last = sec_done && (state_nxt == ST_IDLE);
      if (ph.last && job_r.b2_mode == B2_READ) begin
        ph.read_valid = 1'b1;
        ph.read_data  = job_r.b2;
      end
    end

    ov_nxt = can_emit ? emit : ov_r;
  end

  // Control state and pin levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      ov_r       <= 1'b0;
      sel_lvl_r  <= 1'b1;
      clk_lvl_r  <= 1'b0;
      mosi_lvl_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (emit) begin
        sel_lvl_r  <= ph.cs_n;
        clk_lvl_r  <= ph.sck;
        mosi_lvl_r <= ph.mosi;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (can_emit) begin
      ph_r <= ph;
    end
  end

  assign out_cs_n       = ph_r.cs_n;
  assign out_sck        = ph_r.sck;
  assign out_mosi       = ph_r.mosi;
  assign out_read_data  = ph_r.read_data;
  assign out_read_valid = ph_r.read_valid;
  assign out_last       = ph_r.last;

  a_rv_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ph_r.read_valid) |-> ph_r.last)
    else $error("read byte shown before last phase");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ph_r.read_valid) |-> (ph_r.read_data == 8'h00))
    else $error("read data not clear on non-read phase");

  a_take_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_rd |-> (job_valid && state_r == ST_IDLE))
    else $error("job taken while busy or queue empty");

endmodule

>>> hdl/spi_command_frame_master.sv
// Top level of the SPI command framing master (mode 0, one result per phase).
//
// Usage: each input item is one controller command (in_action with address,
// data, the slave's MISO byte and buffer frame flags), written with push while
// full is low. Every result item is one half-bit pin phase (cs_n, sck, mosi);
// read_data/read_valid carry the assembled byte on a read's final phase and
// last marks the final phase of each command. Results are read queue-style:
// a phase is present while empty is low and is taken with pop.
// Path: a command taken while the engine is idle is registered in the job
// queue, then loaded into the engine's job register, and its first phase is
// then registered in the output register. A command yields 3 to 36 phases,
// one per cycle while pop keeps up; each next job is loaded in the idle state.
// The phase engine is the limit; the front end takes a command per cycle until
// the job queue (JOB_DEPTH entries) fills, and action 7 is taken and dropped.
// Reset (rst_n low, synchronous) empties the queues, closes any buffer frame
// and sets the held pin levels to select high, clock low, data high.
// When the receiver stalls, the current phase is held and the engine waits;
// further commands are taken until the job queue is full.
module spi_command_frame_master
  import spicfm_pkg::*;
#(
  parameter int JOB_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_action,
  input  logic [4:0] in_address,
  input  logic [7:0] in_data,
  input  logic [7:0] in_slave_byte,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  output logic       empty,
  input  logic       pop,
  output logic       out_cs_n,
  output logic       out_sck,
  output logic       out_mosi,
  output logic [7:0] out_read_data,
  output logic       out_read_valid,
  output logic       out_last
);

  logic job_wr;
  job_t job_w;
  logic job_rd;
  job_t job_q;
  logic q_empty;

  // Command classification
  spicfm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .q_full         (full),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_slave_byte  (in_slave_byte),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .job_wr         (job_wr),
    .job            (job_w)
  );

  // Job queue
  spicfm_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (job_wr),
    .wr_job (job_w),
    .rd     (job_rd),
    .rd_job (job_q),
    .full   (full),
    .empty  (q_empty)
  );

  // Phase engine
  spicfm_phase_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (!q_empty),
    .job_in         (job_q),
    .job_rd         (job_rd),
    .pop            (pop),
    .empty          (empty),
    .out_cs_n       (out_cs_n),
    .out_sck        (out_sck),
    .out_mosi       (out_mosi),
    .out_read_data  (out_read_data),
    .out_read_valid (out_read_valid),
    .out_last       (out_last)
  );

endmodule
